### sv/esc_pkg.sv
// Package for the environmental sensor compensation core: widths, register
// indexes, coefficient field helpers and the shared coefficient struct.
// No dependencies.
`timescale 1ns / 1ps
package esc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] RegTemp = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPressA = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPressB = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPressC = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHumid = 3'd4;
  localparam int unsigned DivStages = 32;

  typedef struct packed {
    logic [47:0] t;
    logic [47:0] pa;
    logic [47:0] pb;
    logic [47:0] pc;
    logic [63:0] h;
  } coeffs_t;

  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction
  function automatic logic signed [31:0] zx16(input logic [15:0] v);
    zx16 = {16'd0, v};
  endfunction
endpackage

### sv/env_sensor_compensation_core.sv
// Environmental sensor compensation core: temperature, pressure, humidity.
// Pipeline from start to the result strobe: eight front stages, a 32-stage
// pressure divider (one quotient bit per stage) and two back stages, the last
// being the output register.
// Throughput is one measurement per cycle; busy stays low and the receiver cannot
// stall. Reset clears all valid bits and the coefficient registers to zero.
`timescale 1ns / 1ps
module env_sensor_compensation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [19:0]                   raw_pressure_i,
  input  logic [19:0]                   raw_temperature_i,
  input  logic [15:0]                   raw_humidity_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [esc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [esc_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          done_o,
  output logic signed [15:0]            temperature_centi_o,
  output logic [17:0]                   pressure_pascal_o,
  output logic                          pressure_invalid_o,
  output logic [16:0]                   humidity_q10_o,
  output logic [13:0]                   humidity_centi_o
);
  localparam int unsigned TagW = 1 + 1 + 16 + 17;

  // The pipeline never stalls, so a transfer is taken in every cycle.
  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  esc_pkg::coeffs_t coeffs_q;

  // Coefficient registers; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeffs_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        esc_pkg::RegTemp:   coeffs_q.t <= cfg_data_i[47:0];
        esc_pkg::RegPressA: coeffs_q.pa <= cfg_data_i[47:0];
        esc_pkg::RegPressB: coeffs_q.pb <= cfg_data_i[47:0];
        esc_pkg::RegPressC: coeffs_q.pc <= cfg_data_i[47:0];
        esc_pkg::RegHumid:  coeffs_q.h <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic               f_valid, f_pre;
  logic signed [15:0] f_temp;
  logic [31:0]        f_div, f_num;
  logic [16:0]        f_q10;

  esc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (start & ~busy),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .raw_humidity_i    (raw_humidity_i),
    .coeffs_i          (coeffs_q),
    .valid_o           (f_valid),
    .temp_o            (f_temp),
    .div_o             (f_div),
    .num_o             (f_num),
    .pre_o             (f_pre),
    .q10_o             (f_q10)
  );

  // Tag rides along the divider: pre-shift flag, zero divisor, temperature, humidity.
  logic            f_bad;
  logic [TagW-1:0] d_tag;
  logic [31:0]     d_quo;
  logic            d_valid;
  assign f_bad = (f_div == '0);

  esc_div #(.TagW(TagW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .num_i   (f_num),
    .den_i   (f_bad ? 32'd1 : f_div),
    .tag_i   ({f_pre, f_bad, f_temp, f_q10}),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .tag_o   (d_tag)
  );

  esc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .quo_i   (d_quo),
    .pre_i   (d_tag[TagW-1]),
    .bad_i   (d_tag[TagW-2]),
    .temp_i  (d_tag[32:17]),
    .q10_i   (d_tag[16:0]),
    .pc_i    (coeffs_q.pc),
    .valid_o (done_o),
    .temp_o  (temperature_centi_o),
    .press_o (pressure_pascal_o),
    .bad_o   (pressure_invalid_o),
    .q10_o   (humidity_q10_o),
    .hcent_o (humidity_centi_o)
  );

  // An invalid pressure result always reads as zero pascals.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && pressure_invalid_o |-> pressure_pascal_o == '0)
    else $error("invalid pressure with nonzero value");
  // Humidity stays within its clamp.
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> humidity_q10_o <= 17'd102400 && humidity_centi_o <= 14'd10000)
    else $error("humidity out of range");
  // Front results reach the divider output after exactly its depth.
  a_div_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid |-> ##(esc_pkg::DivStages) d_valid)
    else $error("divider lost an item");
endmodule

### sv/esc_div.sv
// Pipelined restoring divider, 32-bit unsigned, one quotient bit per stage.
// Carries a tag along with each operand pair. Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_div #(
  parameter int unsigned TagW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [31:0]     num_i,
  input  logic [31:0]     den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [31:0]     quo_o,
  output logic [TagW-1:0] tag_o
);
  localparam int unsigned N = esc_pkg::DivStages;
  logic [N-1:0]    vld_q;
  logic [31:0]     rem_q [N];
  logic [31:0]     num_q [N];
  logic [31:0]     den_q [N];
  logic [TagW-1:0] tag_q [N];

  for (genvar s = 0; s < N; s++) begin : g_st
    logic            vld_in;
    logic [31:0]     rem_in;
    logic [31:0]     num_in;
    logic [31:0]     den_in;
    logic [TagW-1:0] tag_in;
    logic [32:0]     trial;
    logic [32:0]     diff;
    if (s == 0) begin : g_head
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_link
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end
    assign trial = {rem_in, num_in[31]};
    assign diff = trial - {1'b0, den_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s] <= diff[32] ? trial[31:0] : diff[31:0];
      num_q[s] <= {num_in[30:0], ~diff[32]};
      den_q[s] <= den_in;
      tag_q[s] <= tag_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o = num_q[N-1];
  assign tag_o = tag_q[N-1];
endmodule

### sv/esc_front.sv
// Front pipeline: temperature, pressure divisor and numerator, humidity.
// Eight register stages. Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [19:0]          raw_pressure_i,
  input  logic [19:0]          raw_temperature_i,
  input  logic [15:0]          raw_humidity_i,
  input  esc_pkg::coeffs_t     coeffs_i,
  output logic                 valid_o,
  output logic signed [15:0]   temp_o,
  output logic [31:0]          div_o,
  output logic [31:0]          num_o,
  output logic                 pre_o,
  output logic [16:0]          q10_o
);
  typedef logic signed [31:0] s32_t;
  s32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, h2, h4, h5, h1, h3, h6;
  assign t1 = esc_pkg::zx16(coeffs_i.t[15:0]);
  assign t2 = esc_pkg::sx16(coeffs_i.t[31:16]);
  assign t3 = esc_pkg::sx16(coeffs_i.t[47:32]);
  assign p1 = esc_pkg::zx16(coeffs_i.pa[15:0]);
  assign p2 = esc_pkg::sx16(coeffs_i.pa[31:16]);
  assign p3 = esc_pkg::sx16(coeffs_i.pa[47:32]);
  assign p4 = esc_pkg::sx16(coeffs_i.pb[15:0]);
  assign p5 = esc_pkg::sx16(coeffs_i.pb[31:16]);
  assign p6 = esc_pkg::sx16(coeffs_i.pb[47:32]);
  assign h1 = {24'd0, coeffs_i.h[7:0]};
  assign h2 = esc_pkg::sx16(coeffs_i.h[23:8]);
  assign h3 = {24'd0, coeffs_i.h[31:24]};
  assign h4 = {{20{coeffs_i.h[43]}}, coeffs_i.h[43:32]};
  assign h5 = {{20{coeffs_i.h[55]}}, coeffs_i.h[55:44]};
  assign h6 = {{24{coeffs_i.h[63]}}, coeffs_i.h[63:56]};

  logic [7:0] vld_q;
  // Stage 1: temperature products.
  s32_t s1_a_q, s1_dd_q;
  logic [19:0] s1_rp_q;
  logic [15:0] s1_rh_q;
  // Stage 2: fine temperature.
  s32_t s2_fine_q;
  s32_t s2_b_q;
  logic [19:0] s2_rp_q;
  logic [15:0] s2_rh_q;
  // Stage 3
  s32_t s3_fine_q, s3_a_q, s3_d_q, s3_ha_q;
  logic signed [15:0] s3_temp_q;
  logic [19:0] s3_rp_q;
  logic [15:0] s3_rh_q;
  // Stage 4
  s32_t s4_dd_q, s4_ap5_q, s4_p2a_q, s4_hd_q, s4_ah6_q, s4_ah3_q;
  logic signed [15:0] s4_temp_q;
  logic [19:0] s4_rp_q;
  // Stage 5
  s32_t s5_b_q, s5_a_q, s5_hb_q, s5_hd_q;
  logic signed [15:0] s5_temp_q;
  logic [19:0] s5_rp_q;
  // Stage 6
  s32_t s6_div_q, s6_pu_q, s6_hb_q, s6_hd_q;
  logic signed [15:0] s6_temp_q;
  // Stage 7: raw humidity product.
  s32_t s7_div_q, s7_pu_q, s7_hum_q;
  logic signed [15:0] s7_temp_q;
  // Stage 8: humidity square term.
  s32_t s8_div_q, s8_pu_q, s8_hum_q, s8_hsq_q;
  logic signed [15:0] s8_temp_q;

  s32_t e1_a, e1_d, e2_b, e3_a, e3_fine;
  logic signed [63:0] e3_temp;
  s32_t e4_b, e4_a, e4_hb, e4_dx;
  s32_t e5_div, e5_pu, e5_hb2;
  s32_t e7_d;

  always_comb begin
    e1_a = s32_t'({12'd0, raw_temperature_i[19:3]}) - (t1 <<< 1);
    e1_d = s32_t'({16'd0, raw_temperature_i[19:4]}) - t1;
    e2_b = s32_t'((s1_dd_q >>> 12) * t3);
    e3_fine = s2_fine_q + s2_b_q;
    e3_temp = (64'(e3_fine) * 5 + 128) >>> 8;
    e3_a = (e3_fine >>> 1) - 32'sd64000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q <= s32_t'(e1_a * t2) >>> 11;
    s1_dd_q <= s32_t'(e1_d * e1_d);
    s1_rp_q <= raw_pressure_i;
    s1_rh_q <= raw_humidity_i;

    s2_fine_q <= s1_a_q;
    s2_b_q <= e2_b >>> 14;
    s2_rp_q <= s1_rp_q;
    s2_rh_q <= s1_rh_q;

    s3_fine_q <= e3_fine;
    s3_a_q <= e3_a;
    s3_d_q <= e3_a >>> 2;
    s3_ha_q <= e3_fine - 32'sd76800;
    s3_rp_q <= s2_rp_q;
    s3_rh_q <= s2_rh_q;
    if (e3_temp > 64'sd32767) s3_temp_q <= 16'sh7fff;
    else if (e3_temp < -64'sd32768) s3_temp_q <= 16'sh8000;
    else s3_temp_q <= e3_temp[15:0];
  end

  // Stage 4 products.
  always_ff @(posedge clk_i) begin
    s4_dd_q <= s32_t'(s3_d_q * s3_d_q);
    s4_ap5_q <= s32_t'(s3_a_q * p5);
    s4_p2a_q <= s32_t'(p2 * s3_a_q);
    s4_hd_q <= (s32_t'({s3_rh_q, 14'd0}) - (h4 <<< 20)) - s32_t'(h5 * s3_ha_q);
    s4_ah6_q <= s32_t'(s3_ha_q * h6) >>> 10;
    s4_ah3_q <= (s32_t'(s3_ha_q * h3) >>> 11) + 32'sd32768;
    s4_temp_q <= s3_temp_q;
    s4_rp_q <= s3_rp_q;
  end

  always_comb begin
    e4_b = s32_t'((s4_dd_q >>> 11) * p6) + (s4_ap5_q <<< 1);
    e4_b = (e4_b >>> 2) + (p4 <<< 16);
    e4_a = ((s32_t'((s4_dd_q >>> 13) * p3) >>> 3) + (s4_p2a_q >>> 1)) >>> 18;
    e4_hb = s32_t'(s4_ah6_q * s4_ah3_q);
    e4_dx = (s4_hd_q + 32'sd16384) >>> 15;
  end

  always_ff @(posedge clk_i) begin
    s5_b_q <= e4_b;
    s5_a_q <= e4_a;
    s5_hb_q <= (e4_hb >>> 10) + 32'sd2097152;
    s5_hd_q <= e4_dx;
    s5_temp_q <= s4_temp_q;
    s5_rp_q <= s4_rp_q;
  end

  always_comb begin
    e5_div = s32_t'((32'sd32768 + s5_a_q) * p1) >>> 15;
    e5_pu = (32'sd1048576 - s32_t'({12'd0, s5_rp_q})) - (s5_b_q >>> 12);
    e5_hb2 = (s32_t'(s5_hb_q * h2) + 32'sd8192) >>> 14;
  end

  always_ff @(posedge clk_i) begin
    s6_div_q <= e5_div;
    s6_pu_q <= s32_t'(e5_pu * 32'sd3125);
    s6_hb_q <= e5_hb2;
    s6_hd_q <= s5_hd_q;
    s6_temp_q <= s5_temp_q;
  end

  always_comb begin
    e7_d = s7_hum_q >>> 15;
  end

  // Stages 7 and 8 finish the humidity products; pressure and temperature wait.
  always_ff @(posedge clk_i) begin
    s7_div_q <= s6_div_q;
    s7_pu_q <= s6_pu_q;
    s7_temp_q <= s6_temp_q;
    s7_hum_q <= s32_t'(s6_hd_q * s6_hb_q);

    s8_div_q <= s7_div_q;
    s8_pu_q <= s7_pu_q;
    s8_temp_q <= s7_temp_q;
    s8_hum_q <= s7_hum_q;
    s8_hsq_q <= s32_t'(e7_d * e7_d) >>> 7;
  end

  // Humidity tail is combinational after stage 8 and registered by the caller.
  s32_t hsub, h1p;
  logic signed [31:0] hq;
  always_comb begin
    h1p = s32_t'(s8_hsq_q * h1) >>> 4;
    hsub = s8_hum_q - h1p;
    if (hsub < 0) hq = 0;
    else if (hsub > 32'sd419430400) hq = 32'sd419430400;
    else hq = hsub;
  end

  assign valid_o = vld_q[7];
  assign temp_o = s8_temp_q;
  assign div_o = s8_div_q;
  assign pre_o = ~s8_pu_q[31];
  assign num_o = s8_pu_q[31] ? s8_pu_q : {s8_pu_q[30:0], 1'b0};
  assign q10_o = hq[28:12];
endmodule

### sv/esc_back.sv
// Back pipeline: pressure correction after the quotient and humidity scaling.
// Two register stages. Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [31:0]        quo_i,
  input  logic               pre_i,
  input  logic               bad_i,
  input  logic signed [15:0] temp_i,
  input  logic [16:0]        q10_i,
  input  logic [47:0]        pc_i,
  output logic               valid_o,
  output logic signed [15:0] temp_o,
  output logic [17:0]        press_o,
  output logic               bad_o,
  output logic [16:0]        q10_o,
  output logic [13:0]        hcent_o
);
  typedef logic signed [31:0] s32_t;
  s32_t p7, p8, p9;
  assign p7 = esc_pkg::sx16(pc_i[15:0]);
  assign p8 = esc_pkg::sx16(pc_i[31:16]);
  assign p9 = esc_pkg::sx16(pc_i[47:32]);

  logic [1:0] vld_q;
  logic [31:0] pu, s1_pu_q;
  logic [31:0] ssq, s1_sq_q;
  s32_t s1_b_q;
  logic s1_bad_q;
  logic signed [15:0] s1_temp_q;
  logic [16:0] s1_q10_q;
  logic [23:0] s1_hc_q;
  logic signed [33:0] pres;
  s32_t pa, corr;

  always_comb begin
    pu = pre_i ? quo_i : {quo_i[30:0], 1'b0};
    ssq = 32'(pu[31:3]) * 32'(pu[31:3]);
    pa = s32_t'(p9 * s32_t'(s1_sq_q)) >>> 12;
    corr = (pa + s1_b_q + p7) >>> 4;
    pres = 34'(signed'({1'b0, s1_pu_q})) + 34'(corr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pu_q <= pu;
    s1_sq_q <= {13'd0, ssq[31:13]};
    s1_b_q <= s32_t'(s32_t'({2'd0, pu[31:2]}) * p8) >>> 13;
    s1_bad_q <= bad_i;
    s1_temp_q <= temp_i;
    s1_q10_q <= q10_i;
    s1_hc_q <= 24'(q10_i) * 24'd100 + 24'd512;

    temp_o <= s1_temp_q;
    bad_o <= s1_bad_q;
    q10_o <= s1_q10_q;
    hcent_o <= s1_hc_q[23:10];
    if (s1_bad_q || pres < 0) press_o <= '0;
    else if (pres > 34'sd262143) press_o <= 18'h3ffff;
    else press_o <= pres[17:0];
  end

  assign valid_o = vld_q[1];
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for env_sensor_compensation_core. It holds its own
// integer compensation predictor and compares every result field by field.
// Depends on esc_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_top;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [esc_pkg::CfgIdxW-1:0] RegSpareLo = 3'd5;
  localparam logic [esc_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;
  localparam int unsigned StallLimit = 600;
  localparam int unsigned DrainCycles = 60;

  // One compensated measurement as the core reports it.
  typedef struct {
    logic signed [15:0] temp_centi;
    logic [17:0]        press_pa;
    logic               press_bad;
    logic [16:0]        hum_q10;
    logic [13:0]        hum_centi;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [19:0] raw_pressure_i = '0;
  logic [19:0] raw_temperature_i = '0;
  logic [15:0] raw_humidity_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [esc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [esc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [15:0] temperature_centi_o;
  logic [17:0] pressure_pascal_o;
  logic pressure_invalid_o;
  logic [16:0] humidity_q10_o;
  logic [13:0] humidity_centi_o;

  // Coefficient shadow that mirrors every accepted register write.
  esc_pkg::coeffs_t cal;
  reading_t pending_readings[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit no_gaps = 1'b0;

  env_sensor_compensation_core DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .raw_pressure_i      (raw_pressure_i),
    .raw_temperature_i   (raw_temperature_i),
    .raw_humidity_i      (raw_humidity_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .done_o              (done_o),
    .temperature_centi_o (temperature_centi_o),
    .pressure_pascal_o   (pressure_pascal_o),
    .pressure_invalid_o  (pressure_invalid_o),
    .humidity_q10_o      (humidity_q10_o),
    .humidity_centi_o    (humidity_centi_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // All intermediate math wraps to 32 bits; these helpers keep that explicit.
  function automatic longint w32(input longint x);
    w32 = longint'(int'(x));
  endfunction

  function automatic longint sgn16(input logic [15:0] v);
    sgn16 = longint'($signed(v));
  endfunction

  function automatic longint sgn12(input logic [11:0] v);
    sgn12 = longint'($signed(v));
  endfunction

  function automatic longint sgn8(input logic [7:0] v);
    sgn8 = longint'($signed(v));
  endfunction

  // Compensates one raw measurement with the current coefficient shadow.
  function automatic reading_t compensate(input logic [19:0] rp_code,
                                          input logic [19:0] rt_code,
                                          input logic [15:0] rh_code);
    reading_t r;
    longint rp, rt, rh, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, h6;
    longint a, b, d, fine, temp, hum, q10, pres, sq;
    logic [31:0] pu, dv, s;
    rp = longint'({44'd0, rp_code});
    rt = longint'({44'd0, rt_code});
    rh = longint'({48'd0, rh_code});
    t1 = longint'({48'd0, cal.t[15:0]});
    t2 = sgn16(cal.t[31:16]);
    t3 = sgn16(cal.t[47:32]);
    p1 = longint'({48'd0, cal.pa[15:0]});
    p2 = sgn16(cal.pa[31:16]);
    p3 = sgn16(cal.pa[47:32]);
    p4 = sgn16(cal.pb[15:0]);
    p5 = sgn16(cal.pb[31:16]);
    p6 = sgn16(cal.pb[47:32]);
    p7 = sgn16(cal.pc[15:0]);
    p8 = sgn16(cal.pc[31:16]);
    p9 = sgn16(cal.pc[47:32]);
    h1 = longint'({56'd0, cal.h[7:0]});
    h2 = sgn16(cal.h[23:8]);
    h3 = longint'({56'd0, cal.h[31:24]});
    h4 = sgn12(cal.h[43:32]);
    h5 = sgn12(cal.h[55:44]);
    h6 = sgn8(cal.h[63:56]);

    // Temperature path produces the fine value shared by the others.
    a = w32(w32((rt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = w32((rt >>> 4) - t1);
    b = w32((w32(d * d) >>> 12) * t3) >>> 14;
    fine = w32(a + b);
    temp = (fine * 5 + 128) >>> 8;
    if (temp > 32767) temp = 32767;
    if (temp < -32768) temp = -32768;

    // Pressure path with the divide done in unsigned 32-bit terms.
    a = w32((fine >>> 1) - 64000);
    d = a >>> 2;
    b = w32((w32(d * d) >>> 11) * p6);
    b = w32(b + w32(w32(a * p5) <<< 1));
    b = w32((b >>> 2) + w32(p4 <<< 16));
    a = w32((w32((w32(d * d) >>> 13) * p3) >>> 3) + (w32(p2 * a) >>> 1));
    a = a >>> 18;
    a = w32(w32(32768 + a) * p1) >>> 15;
    r.press_bad = (a == 0);
    if (r.press_bad) begin
      pres = 0;
    end else begin
      dv = a[31:0];
      b = b >>> 12;
      pu = 32'd1048576 - rp[31:0] - b[31:0];
      pu = pu * 32'd3125;
      if (pu < 32'h8000_0000) pu = (pu << 1) / dv;
      else pu = (pu / dv) << 1;
      s = pu >> 3;
      s = s * s;
      sq = longint'({32'd0, s >> 13});
      a = w32(p9 * sq) >>> 12;
      b = w32(longint'({32'd0, pu >> 2}) * p8) >>> 13;
      pres = longint'({32'd0, pu}) + (w32(a + b + p7) >>> 4);
      if (pres < 0) pres = 0;
      if (pres > 262143) pres = 262143;
    end

    // Humidity path, clamped before the final scaling.
    a = w32(fine - 76800);
    d = w32(w32(w32(rh <<< 14) - w32(h4 <<< 20)) - w32(h5 * a));
    d = w32(d + 16384) >>> 15;
    b = w32((w32(a * h6) >>> 10) * w32((w32(a * h3) >>> 11) + 32768));
    b = w32((b >>> 10) + 2097152);
    b = w32(w32(b * h2) + 8192) >>> 14;
    hum = w32(d * b);
    d = hum >>> 15;
    hum = w32(hum - (w32((w32(d * d) >>> 7) * h1) >>> 4));
    if (hum < 0) hum = 0;
    if (hum > 419430400) hum = 419430400;
    q10 = hum >>> 12;

    r.temp_centi = temp[15:0];
    r.press_pa = pres[17:0];
    r.hum_q10 = q10[16:0];
    r.hum_centi = 14'((q10 * 100 + 512) >>> 10);
    return r;
  endfunction

  // Result checker: the core cannot be held off, so every strobe is a transfer.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && done_o) begin
      if (pending_readings.size() == 0) begin
        $error("result with no measurement outstanding");
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if (temperature_centi_o !== want.temp_centi) begin
          $error("temperature_centi: expected %0d, got %0d", want.temp_centi,
                 temperature_centi_o);
          errors++;
        end
        if (pressure_pascal_o !== want.press_pa) begin
          $error("pressure_pascal: expected %0d, got %0d", want.press_pa,
                 pressure_pascal_o);
          errors++;
        end
        if (pressure_invalid_o !== want.press_bad) begin
          $error("pressure_invalid: expected %0b, got %0b", want.press_bad,
                 pressure_invalid_o);
          errors++;
        end
        if (humidity_q10_o !== want.hum_q10) begin
          $error("humidity_q10: expected %0d, got %0d", want.hum_q10, humidity_q10_o);
          errors++;
        end
        if (humidity_centi_o !== want.hum_centi) begin
          $error("humidity_centi: expected %0d, got %0d", want.hum_centi,
                 humidity_centi_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel resets the stall count.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("env_sensor_compensation_core: mismatch");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  task automatic idle_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) len = 0;
    else if (roll < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len != 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end
  endtask

  // Presents one measurement and records its prediction on the transfer.
  task automatic send_measurement(input logic [19:0] rp, input logic [19:0] rt,
                                  input logic [15:0] rh);
    @(negedge clk_i);
    start = 1'b1;
    raw_pressure_i = rp;
    raw_temperature_i = rt;
    raw_humidity_i = rh;
    do @(posedge clk_i); while (busy);
    pending_readings.push_back(compensate(rp, rt, rh));
    idle_gap();
  endtask

  // Register writes happen only with the pipeline drained.
  task automatic write_coeff(input logic [esc_pkg::CfgIdxW-1:0] idx,
                             input logic [63:0] value);
    @(negedge clk_i);
    start = 1'b0;
    wait (pending_readings.size() == 0);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      esc_pkg::RegTemp:   cal.t = value[47:0];
      esc_pkg::RegPressA: cal.pa = value[47:0];
      esc_pkg::RegPressB: cal.pb = value[47:0];
      esc_pkg::RegPressC: cal.pc = value[47:0];
      esc_pkg::RegHumid:  cal.h = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_all(input esc_pkg::coeffs_t c);
    write_coeff(esc_pkg::RegTemp, {16'd0, c.t});
    write_coeff(esc_pkg::RegPressA, {16'd0, c.pa});
    write_coeff(esc_pkg::RegPressB, {16'd0, c.pb});
    write_coeff(esc_pkg::RegPressC, {16'd0, c.pc});
    write_coeff(esc_pkg::RegHumid, c.h);
  endtask

  // Typical factory calibration, used as the center of the random sets.
  function automatic esc_pkg::coeffs_t nominal_cal();
    esc_pkg::coeffs_t c;
    c.t  = {16'(-1000), 16'(26435), 16'(27504)};
    c.pa = {16'(3024), 16'(-10685), 16'(36477)};
    c.pb = {16'(-7), 16'(140), 16'(2855)};
    c.pc = {16'(6000), 16'(-14600), 16'(15500)};
    c.h  = {8'(30), 12'(50), 12'(313), 8'(0), 16'(362), 8'(75)};
    return c;
  endfunction

  // Either a perturbed nominal set or a fully random one.
  function automatic esc_pkg::coeffs_t random_cal(input bit wild);
    esc_pkg::coeffs_t c;
    c = nominal_cal();
    if (wild) begin
      c.t = 48'({$urandom, $urandom});
      c.pa = 48'({$urandom, $urandom});
      c.pb = 48'({$urandom, $urandom});
      c.pc = 48'({$urandom, $urandom});
      c.h = {$urandom, $urandom};
    end else begin
      c.t[15:0] = c.t[15:0] + 16'($urandom_range(0, 2000)) - 16'd1000;
      c.t[31:16] = c.t[31:16] + 16'($urandom_range(0, 2000)) - 16'd1000;
      c.pa[15:0] = c.pa[15:0] + 16'($urandom_range(0, 4000)) - 16'd2000;
      c.pb[31:16] = 16'($urandom_range(0, 400)) - 16'd200;
      c.pc[47:32] = 16'($urandom_range(0, 8000)) - 16'd4000;
      c.h[7:0] = 8'($urandom);
      c.h[31:24] = 8'($urandom);
      c.h[63:56] = 8'($urandom);
    end
    return c;
  endfunction

  // After reset every coefficient is zero, so the divisor is zero.
  task automatic test_reset_coeffs();
    send_measurement(20'd0, 20'd0, 16'd0);
    send_measurement(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_measurement(20'd415148, 20'd519888, 16'd30000);
  endtask

  // Field extremes under a realistic calibration.
  task automatic test_field_extremes();
    load_all(nominal_cal());
    send_measurement(20'd0, 20'd0, 16'd0);
    send_measurement(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_measurement(20'hFFFFF, 20'd0, 16'hFFFF);
    send_measurement(20'd0, 20'hFFFFF, 16'd0);
    send_measurement(20'h55555, 20'hAAAAA, 16'h5555);
    send_measurement(20'd415148, 20'd519888, 16'd30000);
  endtask

  // Coefficient extremes: all ones, sign-bit-only, a zero P1 forcing an
  // invalid pressure, and a negative divisor read as unsigned.
  task automatic test_coeff_extremes();
    esc_pkg::coeffs_t c;
    load_all('1);
    send_measurement(20'd415148, 20'd519888, 16'd30000);
    send_measurement(20'hFFFFF, 20'd0, 16'hFFFF);
    load_all({48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
              48'h8000_8000_8000, 64'h8080_0800_8080_0080});
    send_measurement(20'd0, 20'hFFFFF, 16'd0);
    send_measurement(20'd415148, 20'd519888, 16'hFFFF);
    c = nominal_cal();
    c.pa[15:0] = 16'd0;
    load_all(c);
    send_measurement(20'd415148, 20'd519888, 16'd30000);
    c = nominal_cal();
    c.pa[31:16] = 16'h7FFF;
    c.pa[47:32] = 16'h7FFF;
    load_all(c);
    send_measurement(20'd415148, 20'hFFFFF, 16'd30000);
    send_measurement(20'd0, 20'd0, 16'hFFFF);
  endtask

  // Writes to spare indexes must leave the calibration untouched.
  task automatic test_spare_index();
    load_all(nominal_cal());
    write_coeff(RegSpareLo, '1);
    write_coeff(RegSpareHi, 64'h8000_0000_0000_0001);
    send_measurement(20'd415148, 20'd519888, 16'd30000);
    send_measurement(20'd300000, 20'd480000, 16'd45000);
  endtask

  // Random phases, each with a fresh calibration; raw codes mostly near the
  // working range so the pressure and humidity paths see sensible values.
  task automatic test_random_stream(input int unsigned phases, input int unsigned per_phase);
    int unsigned roll;
    logic [19:0] rp, rt;
    logic [15:0] rh;
    for (int unsigned ph = 0; ph < phases; ph++) begin
      load_all(random_cal(ph % 4 == 3));
      no_gaps = (ph % 5 == 1);
      for (int unsigned n = 0; n < per_phase; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          rp = 20'($urandom_range(200000, 600000));
          rt = 20'($urandom_range(400000, 650000));
          rh = 16'($urandom_range(15000, 50000));
        end else begin
          rp = 20'($urandom);
          rt = 20'($urandom);
          rh = 16'($urandom);
        end
        send_measurement(rp, rt, rh);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    cal = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_coeffs();
    test_field_extremes();
    test_coeff_extremes();
    test_spare_index();
    test_random_stream(10, 200);

    @(negedge clk_i);
    start = 1'b0;
    wait (pending_readings.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("env_sensor_compensation_core: match");
    end else begin
      $display("env_sensor_compensation_core: mismatch");
    end
    $finish;
  end
endmodule
